@@ rtl/core/pwms_pkg.sv @@
// package for the power weighted modular sum unit
// shared widths, defaults and the modular multiplier request and response types; no dependencies
package pwms_pkg;
    localparam int unsigned PRIME_BITS_DEF = 32;
    localparam int unsigned TABLE_BITS_DEF = 32;
    localparam int unsigned T_W            = 17;
    localparam int unsigned SUM_W          = 35;
    localparam int unsigned MOD_W          = 36;
    localparam int unsigned PRIME_W        = 32;

    typedef struct packed {
        logic             start;
        logic [MOD_W-1:0] a;
        logic [MOD_W-1:0] b;
        logic [MOD_W-1:0] m;
    } t_mm_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [MOD_W-1:0] r;
    } t_mm_rsp;
endpackage

@@ rtl/core/pwms_mulmod.sv @@
// serial modular multiplier: one bit of b per cycle, shift-and-add mod m
// depends on pwms_pkg; inputs a and b must already be below m
module pwms_mulmod (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pwms_pkg::t_mm_req i_req,
    output pwms_pkg::t_mm_rsp o_rsp
);
    import pwms_pkg::*;

    localparam int unsigned CNT_W = $clog2(MOD_W);

    logic [MOD_W-1:0] r_a, r_b, r_m, r_r, n_r;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [MOD_W:0]   w_dbl, w_dbl_red, w_add;

    always_comb begin
        w_dbl     = {r_r, 1'b0};
        w_dbl_red = (w_dbl >= {1'b0, r_m}) ? w_dbl - {1'b0, r_m} : w_dbl;
        w_add     = w_dbl_red + {1'b0, r_a};
        if (r_b[MOD_W-1]) begin
            n_r = (w_add >= {1'b0, r_m}) ? MOD_W'(w_add - {1'b0, r_m}) : MOD_W'(w_add);
        end else begin
            n_r = MOD_W'(w_dbl_red);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MOD_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
            r_m <= i_req.m;
            r_r <= '0;
        end else if (r_busy) begin
            r_r <= n_r;
            r_b <= {r_b[MOD_W-2:0], 1'b0};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.r    = r_r;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && (r_m != '0) |-> r_r < r_m) else $error("result not reduced");
    a_busy_holds_m: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && $past(r_busy) |-> $stable(r_m)) else $error("modulus changed");
endmodule

@@ rtl/core/power_weighted_modular_sum_unit.sv @@
// power weighted modular sum unit: sum of (t^10 mod m)*h mod m, m = 6(p+1)
// depends on pwms_pkg and pwms_mulmod
//
//  channel | dir | handshake        | payload
//  in      | in  | i_valid/o_stall  | first_item prime t_first sum_in hval last_item
//  out     | out | o_valid/i_stall  | prime_out sum_out hit
//
// an item goes through these steps between one input transfer and the next: t is reduced mod m,
// five serial modular multiplies go through the one shared multiplier,
// then one accumulate step and one t step; while m is still zero only the t step follows
// a first item adds a restoring reduction of sum_in by m<<k before the reduction of t
// a last item adds a step that loads the result register, held while that register waits
// reset is synchronous active low and clears control and run state
// the input stalls while an item is worked or a result waits behind a stalled output
module power_weighted_modular_sum_unit #(
    parameter int unsigned PRIME_BITS = pwms_pkg::PRIME_BITS_DEF,
    parameter int unsigned TABLE_BITS = pwms_pkg::TABLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_first_item,
    input  logic [PRIME_BITS-1:0] i_prime,
    input  logic [pwms_pkg::T_W-1:0]   i_t_first,
    input  logic [pwms_pkg::SUM_W-1:0] i_sum_in,
    input  logic [TABLE_BITS-1:0] i_hval,
    input  logic                  i_last_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [pwms_pkg::PRIME_W-1:0] o_prime_out,
    output logic [pwms_pkg::SUM_W-1:0]   o_sum_out,
    output logic                  o_hit
);
    import pwms_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RED  = 8'b0000_0010,
        S_TRED = 8'b0000_0100,
        S_MUL  = 8'b0000_1000,
        S_WAIT = 8'b0001_0000,
        S_ACC  = 8'b0010_0000,
        S_OUT  = 8'b0100_0000,
        S_HOLD = 8'b1000_0000
    } t_state;

    localparam int unsigned SH_W = $clog2(MOD_W);

    t_state            r_state;
    logic [PRIME_W-1:0] r_prime;
    logic [MOD_W-1:0]  r_mod, r_acc, r_t2, r_x, r_h, r_tm;
    logic [T_W-1:0]    r_t;
    logic [2:0]        r_step;
    logic [SH_W-1:0]   r_sh;
    logic              r_last;
    logic              r_ovalid;
    logic [PRIME_W-1:0] r_oprime;
    logic [SUM_W-1:0]  r_osum;
    t_mm_req           w_req;
    t_mm_rsp           w_rsp;
    logic              w_take;
    logic [MOD_W+MOD_W-1:0] w_msh;
    logic [MOD_W:0]    w_acc_add;

    assign w_take  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);
    // shifted modulus for the restoring reduction steps
    assign w_msh   = {{MOD_W{1'b0}}, r_mod} << r_sh;
    assign w_acc_add = {1'b0, r_acc} + {1'b0, r_x};

    // multiplier operands per step: t*t, t2*t2, t4*t4, t8*t2, p10*h
    // h goes in as the bit-serial operand, so it needs no reduction
    always_comb begin
        w_req.start = (r_state == S_MUL);
        w_req.m     = r_mod;
        unique case (r_step)
            3'd0:    begin w_req.a = r_tm; w_req.b = r_tm; end
            3'd1:    begin w_req.a = r_x;  w_req.b = r_x;  end
            3'd2:    begin w_req.a = r_x;  w_req.b = r_x;  end
            3'd3:    begin w_req.a = r_x;  w_req.b = r_t2; end
            default: begin w_req.a = r_x;  w_req.b = r_h;  end
        endcase
    end

    pwms_mulmod u_mm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prime  <= '0;
            r_mod    <= '0;
            r_acc    <= '0;
            r_t      <= '0;
            r_ovalid <= 1'b0;
            r_step   <= '0;
            r_sh     <= '0;
            r_last   <= 1'b0;
        end else begin
            // result transfer frees the output register unless a new result loads now
            if (r_ovalid && !i_stall && r_state != S_HOLD) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_h    <= MOD_W'(i_hval);
                        r_last <= i_last_item;
                        if (i_first_item) begin
                            r_prime <= PRIME_W'(i_prime);
                            r_mod   <= MOD_W'(({3'b0, i_prime} + 1'b1) * 3'd6);
                            r_t     <= i_t_first;
                            r_acc   <= MOD_W'(i_sum_in);
                            r_sh    <= SH_W'(MOD_W - 1);
                            r_state <= S_RED;
                        end else begin
                            r_tm    <= {{(MOD_W-T_W){1'b0}}, r_t};
                            r_sh    <= SH_W'(T_W - 1);
                            r_state <= S_TRED;
                        end
                    end
                end
                S_RED: begin
                    // restoring reduction of the carried sum, one shift a cycle
                    if (r_mod != '0 && w_msh[MOD_W+MOD_W-1:MOD_W] == '0
                        && {1'b0, r_acc} >= w_msh[MOD_W:0]) begin
                        r_acc <= r_acc - w_msh[MOD_W-1:0];
                    end
                    if (r_sh == '0) begin
                        r_tm    <= {{(MOD_W-T_W){1'b0}}, r_t};
                        r_sh    <= SH_W'(T_W - 1);
                        r_state <= S_TRED;
                    end else begin
                        r_sh <= r_sh - 1'b1;
                    end
                end
                S_TRED: begin
                    // no modulus yet: nothing accumulates, t still steps
                    if (r_mod == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        // restoring reduction of t mod m, one shift a cycle
                        if (w_msh[MOD_W+MOD_W-1:MOD_W] == '0
                            && {1'b0, r_tm} >= w_msh[MOD_W:0]) begin
                            r_tm <= r_tm - w_msh[MOD_W-1:0];
                        end
                        if (r_sh == '0) begin
                            r_step  <= '0;
                            r_state <= S_MUL;
                        end else begin
                            r_sh <= r_sh - 1'b1;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_rsp.done) begin
                        r_x <= w_rsp.r;
                        if (r_step == 3'd0) begin
                            r_t2 <= w_rsp.r;
                        end
                        if (r_step == 3'd4) begin
                            r_state <= S_ACC;
                        end else begin
                            r_step  <= r_step + 1'b1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_ACC: begin
                    r_acc   <= (w_acc_add >= {1'b0, r_mod}) ?
                               MOD_W'(w_acc_add - {1'b0, r_mod}) : MOD_W'(w_acc_add);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_t <= r_t + 1'b1;
                    if (r_last) begin
                        r_state <= S_HOLD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_HOLD: begin
                    // wait for the output register to free up
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_oprime <= r_prime;
                        r_osum   <= SUM_W'(r_acc);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_prime_out = r_oprime;
    assign o_sum_out   = r_osum;
    assign o_hit       = (r_osum == '0);

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("input taken while busy");
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && (r_mod != '0) |-> r_acc < r_mod) else $error("sum not reduced");
    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> !w_rsp.busy) else $error("multiplier busy on start");
endmodule

@@ dv/testbench.sv @@
// self-checking testbench for power_weighted_modular_sum_unit
// depends on pwms_pkg and the unit rtl; predicts run sums and checks every result transfer
`timescale 1ns / 100ps

module testbench;
    import pwms_pkg::*;

    localparam int unsigned PB = PRIME_BITS_DEF;
    localparam int unsigned TB = TABLE_BITS_DEF;

    typedef struct packed {
        logic             first;
        logic [PB-1:0]    prime;
        logic [T_W-1:0]   t_first;
        logic [SUM_W-1:0] sum_in;
        logic [TB-1:0]    hval;
        logic             last;
        logic             drain;    // hold off until all sums are back
    } t_item;

    typedef struct packed {
        logic [PRIME_W-1:0] prime;
        logic [SUM_W-1:0]   sum;
        logic               hit;
    } t_run_sum;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    logic             i_first_item, i_last_item, o_hit;
    logic [PB-1:0]    i_prime;
    logic [T_W-1:0]   i_t_first;
    logic [SUM_W-1:0] i_sum_in, o_sum_out;
    logic [TB-1:0]    i_hval;
    logic [PRIME_W-1:0] o_prime_out;

    power_weighted_modular_sum_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_first_item(i_first_item), .i_prime(i_prime), .i_t_first(i_t_first),
        .i_sum_in(i_sum_in), .i_hval(i_hval), .i_last_item(i_last_item),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_prime_out(o_prime_out), .o_sum_out(o_sum_out), .o_hit(o_hit)
    );

    t_item    pending_items[$];
    t_run_sum expected_sums[$];
    int       errors = 0;
    bit       stim_done = 0;

    // predictor copy of the run state
    logic [PRIME_W-1:0] run_prime;
    logic [MOD_W-1:0]   run_mod;
    logic [T_W-1:0]     run_t;
    logic [MOD_W-1:0]   run_acc;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    // mostly short gaps, a few long ones, and idle-free stretches
    function automatic int pick_gap(bit burst);
        if (burst) return 0;
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        return $urandom_range(5, 60);
    endfunction

    function automatic logic [MOD_W-1:0] mod_mul(logic [MOD_W-1:0] a, logic [MOD_W-1:0] b,
                                                 logic [MOD_W-1:0] m);
        logic [71:0] p;
        p = {36'd0, a} * {36'd0, b};
        return MOD_W'(p % {36'd0, m});
    endfunction

    // one accepted transfer: latch, accumulate t^10 * h, step t, maybe emit
    task automatic predict_run(t_item it);
        logic [MOD_W-1:0] t2, t4, t8, p10, term;
        t_run_sum r;
        if (it.first) begin
            run_prime = it.prime;
            run_mod   = 36'd6 * ({4'd0, it.prime} + 36'd1);
            run_t     = it.t_first;
            run_acc   = {1'b0, it.sum_in} % run_mod;
        end
        if (run_mod != 0) begin
            t2   = mod_mul({19'd0, run_t}, {19'd0, run_t}, run_mod);
            t4   = mod_mul(t2, t2, run_mod);
            t8   = mod_mul(t4, t4, run_mod);
            p10  = mod_mul(t8, t2, run_mod);
            term = mod_mul(p10, {4'd0, it.hval}, run_mod);
            run_acc = (run_acc + term) % run_mod;
        end
        run_t = run_t + 1'b1;   // 17-bit wrap
        if (it.last) begin
            r.prime = run_prime;
            r.sum   = run_acc[SUM_W-1:0];
            r.hit   = (run_acc == 0);
            expected_sums.push_back(r);
        end
    endtask

    function automatic t_item mk(bit f, logic [31:0] p, logic [16:0] t, logic [34:0] s,
                                 logic [31:0] h, bit l);
        t_item it;
        it = '{f, p, t, s, h, l, 1'b0};
        return it;
    endfunction

    // ---------------- driver ----------------
    int  drv_gap;
    bit  drv_burst;
    always @(posedge i_clk) begin
        t_item nxt;
        if (!i_rst_n) begin
            i_valid <= 0;
            drv_gap = 0;
            drv_burst = 0;
            run_prime = '0; run_mod = '0; run_t = '0; run_acc = '0;
        end else begin
            if ($urandom_range(0, 199) == 0) drv_burst = ~drv_burst;
            if (!i_valid || !o_stall) begin
                // a transfer happens at this edge when valid is high
                if (i_valid) begin
                    predict_run('{i_first_item, i_prime, i_t_first, i_sum_in, i_hval,
                                  i_last_item, 1'b0});
                    drv_gap = pick_gap(drv_burst);
                end
                if (drv_gap > 0) begin
                    drv_gap--;
                    i_valid <= 0;
                end else if (pending_items.size() != 0 &&
                             !(pending_items[0].drain && expected_sums.size() != 0)) begin
                    nxt = pending_items.pop_front();
                    i_valid      <= 1;
                    i_first_item <= nxt.first;
                    i_prime      <= nxt.prime;
                    i_t_first    <= nxt.t_first;
                    i_sum_in     <= nxt.sum_in;
                    i_hval       <= nxt.hval;
                    i_last_item  <= nxt.last;
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    int  mon_gap;
    bit  mon_burst;
    always @(posedge i_clk) begin
        t_run_sum e;
        if (!i_rst_n) begin
            i_stall <= 0;
            mon_gap = 0;
            mon_burst = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_sums.size() == 0) begin
                    $error("result transfer with no sum pending: prime %0d", o_prime_out);
                    errors++;
                end else begin
                    e = expected_sums.pop_front();
                    if (o_prime_out !== e.prime) begin
                        $error("prime_out expected %0d actual %0d", e.prime, o_prime_out);
                        errors++;
                    end
                    if (o_sum_out !== e.sum) begin
                        $error("sum_out expected %0d actual %0d", e.sum, o_sum_out);
                        errors++;
                    end
                    if (o_hit !== e.hit) begin
                        $error("hit expected %0d actual %0d", e.hit, o_hit);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 149) == 0) mon_burst = ~mon_burst;
            if (mon_gap > 0) begin
                mon_gap--;
                i_stall <= 1;
            end else begin
                mon_gap = ($urandom_range(0, 3) == 0) ? pick_gap(mon_burst) : 0;
                i_stall <= (mon_gap > 0);
            end
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        t_item it;
        int n, k;
        logic [31:0] p;
        i_rst_n = 0;
        i_valid = 0; i_stall = 0;
        i_first_item = 0; i_prime = 0; i_t_first = 0; i_sum_in = 0; i_hval = 0;
        i_last_item = 0;

        // items before any first item, then a last with nothing latched
        pending_items.push_back(mk(0, 32'd7, 17'd5, 35'd3, 32'hFFFF_FFFF, 0));
        pending_items.push_back(mk(0, 32'd7, 17'd5, 35'd3, 32'd9, 1));
        // first and last on one item, smallest prime
        pending_items.push_back(mk(1, 32'd2, 17'd1, 35'd0, 32'd1, 1));
        // largest prime, carried sum out of range, extreme table values
        pending_items.push_back(mk(1, 32'hFFFF_FFFF, 17'h1FFFF, 35'h7_FFFF_FFFF, 32'hFFFF_FFFF, 0));
        pending_items.push_back(mk(0, 32'd0, 17'd0, 35'd0, 32'd0, 0));
        pending_items.push_back(mk(0, 32'd0, 17'd0, 35'd0, 32'hFFFF_FFFF, 1));
        // keeps accumulating after a last with no new first
        pending_items.push_back(mk(0, 32'd0, 17'd0, 35'd0, 32'd12345, 1));
        // t wraps through zero
        pending_items.push_back(mk(1, 32'd101, 17'd131070, 35'd50, 32'd77, 0));
        for (k = 0; k < 3; k++)
            pending_items.push_back(mk(0, 32'd0, 17'd0, 35'd0, 32'd1000 + k, k == 2));
        // t_first of zero, zero prime, prime of one
        pending_items.push_back(mk(1, 32'd0, 17'd0, 35'd5, 32'd4, 1));
        pending_items.push_back(mk(1, 32'd1, 17'd0, 35'd11, 32'd3, 0));
        pending_items.push_back(mk(0, 32'd0, 17'd1, 35'd0, 32'd2, 1));
        // sum that lands exactly on zero: m = 18, sum_in 18 reduces to 0, h = 0
        pending_items.push_back(mk(1, 32'd2, 17'd3, 35'd18, 32'd0, 1));
        it = mk(1, 32'h8000_0000, 17'h10000, 35'h4_0000_0000, 32'h8000_0000, 1);
        it.drain = 1;
        pending_items.push_back(it);

        // random part: mostly well-formed runs, some noise
        while (pending_items.size() < 950) begin
            if ($urandom_range(0, 9) == 0) begin
                it = mk(1'($urandom_range(0, 1)), $urandom, 17'($urandom_range(0, 131071)),
                        35'({$urandom, $urandom}), $urandom,
                        1'($urandom_range(0, 1)));
                pending_items.push_back(it);
            end else begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                p = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 1000) : $urandom;
                for (k = 0; k < n; k++) begin
                    it = mk(k == 0, (k == 0) ? p : $urandom, 17'($urandom_range(0, 131071)),
                            35'({$urandom, $urandom}), $urandom, k == n - 1);
                    it.drain = (k == 0) && ($urandom_range(0, 39) == 0);
                    pending_items.push_back(it);
                end
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        wait (pending_items.size() == 0);
        @(posedge i_clk);
        while (i_valid) @(posedge i_clk);
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (errors == 0 && expected_sums.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (expected_sums.size() != 0)
                $error("%0d run sums never arrived", expected_sums.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
